[rtl/smx_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// smx_pkg
// Shared types and constants of the stack machine executor: beat layouts,
// opcodes, fault codes and default sizes.
// ============================================================================
package smx_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int PC_BITS     = 16;
    localparam int DATA_W      = 16;

    // opcode numbering
    typedef enum logic [3:0] {
        OP_EXIT  = 4'd0,
        OP_ADD   = 4'd1,
        OP_PUSH  = 4'd2,
        OP_PRINT = 4'd3,
        OP_LESS  = 4'd4,
        OP_LOAD  = 4'd5,
        OP_STORE = 4'd6,
        OP_JZ    = 4'd7,
        OP_JUMP  = 4'd8
    } t_opcode;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_UNDER = 2'd1,
        FLT_OVER  = 2'd2,
        FLT_SLOT  = 2'd3
    } t_fault;

    typedef struct packed {
        logic        [3:0]  kind;
        logic signed [15:0] operand;
    } t_in_beat;

    typedef struct packed {
        logic        [15:0] next_pc;
        logic               print_valid;
        logic signed [15:0] print_value;
        logic               halted;
        logic        [1:0]  fault;
        logic        [8:0]  stack_level;
    } t_out_beat;

endpackage

[rtl/stack_machine_executor_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// stack_machine_executor_unit
// 16-bit stack machine: one instruction per input beat, one result beat out.
// ============================================================================
// usage
//   input channel  : i_in_valid / o_in_ready / i_in_beat (opcode, operand)
//   output channel : o_out_valid / i_out_ready / o_out_beat (next pc, print,
//                    halted, fault, stack level)
//   an accepted instruction lands in the input register while the stack
//   memory read it needs is issued on the same edge; the next edge at which
//   the result register is free or being drained executes it and loads
//   that register
//   throughput is one instruction per cycle while the receiver keeps up;
//   the top of stack lives in a register and the memory holds the entries
//   below it, so every opcode needs at most one memory read and one write
//   the pop read address of an incoming beat is taken from the stack
//   pointer the executing instruction leaves behind, a load reads its slot;
//   a same-cycle write to the read address is forwarded
//   reset (i_rst_n low, synchronous) empties both stages, sets pc and stack
//   pointer to zero and clears halt; the stack memory is not cleared
//   when the receiver stalls, the result register holds, the executing beat
//   waits and o_in_ready drops once the input register is full
// ============================================================================
module stack_machine_executor_unit #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH,
    parameter int PC_BITS     = smx_pkg::PC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  smx_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output smx_pkg::t_out_beat o_out_beat
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    // input stage
    logic               r_in_valid;
    smx_pkg::t_in_beat  r_in;
    logic               r_fwd_hit;
    logic [15:0]        r_fwd_data;

    // architectural state
    logic [SPW-1:0]     r_sp;
    logic [15:0]        r_tos;
    logic [PC_BITS-1:0] r_pc;
    logic               r_halt;

    // result register
    logic               r_out_valid;
    smx_pkg::t_out_beat r_out;

    logic               fire;
    logic               accept;
    logic [SPW-1:0]     n_sp;
    logic [SPW-1:0]     ex_sp;
    logic [15:0]        ex_tos;
    logic [PC_BITS-1:0] ex_pc;
    logic               ex_halt;
    logic               ex_we;
    logic [AW-1:0]      ex_waddr;
    logic [15:0]        ex_wdata;
    smx_pkg::t_out_beat ex_result;
    logic               mem_we;
    logic [AW-1:0]      raddr;
    logic [31:0]        pop_addr_u;
    logic [31:0]        slot_addr_u;
    logic [15:0]        ram_rdata;
    logic [15:0]        rdata;

    // handshake: execute when the result register is free or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    // stack pointer that the incoming beat will see
    assign n_sp = fire ? ex_sp : r_sp;

    // pops read the entry just below the top, load reads its slot
    assign pop_addr_u  = 32'(n_sp) - 32'd2;
    assign slot_addr_u = 32'(i_in_beat.operand[15:0]);
    assign raddr = (i_in_beat.kind == smx_pkg::OP_LOAD) ? slot_addr_u[AW-1:0]
                                                         : pop_addr_u[AW-1:0];

    assign mem_we = fire && ex_we;

    smx_ram #(
        .WIDTH (16),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ex_waddr),
        .i_wdata (ex_wdata),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // the ram returns old data on a same-cycle write, so patch it here
    assign rdata = r_fwd_hit ? r_fwd_data : ram_rdata;

    smx_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_BITS     (PC_BITS)
    ) u_exec (
        .i_instr     (r_in),
        .i_rdata     (rdata),
        .i_sp        (r_sp),
        .i_tos       (r_tos),
        .i_pc        (r_pc),
        .i_halt      (r_halt),
        .o_sp        (ex_sp),
        .o_tos       (ex_tos),
        .o_pc        (ex_pc),
        .o_halt      (ex_halt),
        .o_mem_we    (ex_we),
        .o_mem_waddr (ex_waddr),
        .o_mem_wdata (ex_wdata),
        .o_result    (ex_result)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
            r_pc        <= '0;
            r_halt      <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_sp        <= ex_sp;
                r_pc        <= ex_pc;
                r_halt      <= ex_halt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in       <= i_in_beat;
            r_fwd_hit  <= mem_we && (ex_waddr == raddr);
            r_fwd_data <= ex_wdata;
        end
        if (fire) begin
            r_tos <= ex_tos;
            r_out <= ex_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

[rtl/smx_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// smx_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module smx_ram #(
    parameter int WIDTH = smx_pkg::DATA_W,
    parameter int DEPTH = smx_pkg::STACK_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/smx_exec.sv]
`timescale 1ns / 1ps
// ============================================================================
// smx_exec
// Execute logic for one instruction: next stack pointer, top of stack,
// program counter and halt flag, the stack memory write and the result beat.
// ============================================================================
module smx_exec #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH,
    parameter int PC_BITS     = smx_pkg::PC_BITS,
    localparam int AW         = $clog2(STACK_DEPTH),
    localparam int SPW        = $clog2(STACK_DEPTH + 1)
) (
    input  smx_pkg::t_in_beat  i_instr,
    input  logic [15:0]        i_rdata,   // stack entry below top, or slot value
    input  logic [SPW-1:0]     i_sp,
    input  logic [15:0]        i_tos,
    input  logic [PC_BITS-1:0] i_pc,
    input  logic               i_halt,
    output logic [SPW-1:0]     o_sp,
    output logic [15:0]        o_tos,
    output logic [PC_BITS-1:0] o_pc,
    output logic               o_halt,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [15:0]        o_mem_wdata,
    output smx_pkg::t_out_beat o_result
);

    logic [31:0]        sp_u;
    logic [31:0]        op_u;
    logic [31:0]        delta_u;
    logic [31:0]        spm1_u;
    logic [31:0]        pc_u;
    logic [31:0]        lvl_u;
    logic               sp_full;
    logic               slot_bad;
    logic               hit_top;
    logic               hit_second;
    logic [SPW-1:0]     sp_inc;
    logic [SPW-1:0]     sp_dec;
    logic [15:0]        sum;
    logic               lt;
    logic [PC_BITS-1:0] delta;
    logic [1:0]         fault;
    logic               pv_valid;
    logic [15:0]        pv;

    assign sp_u       = 32'(i_sp);
    assign op_u       = 32'(i_instr.operand[15:0]);
    assign delta_u    = 32'(i_instr.operand);
    assign spm1_u     = sp_u - 32'd1;
    assign sp_full    = sp_u >= 32'(STACK_DEPTH);
    assign slot_bad   = i_instr.operand[15] || (op_u >= sp_u);
    assign hit_top    = (op_u + 32'd1) == sp_u;
    assign hit_second = (op_u + 32'd2) == sp_u;
    assign sp_inc     = i_sp + SPW'(1);
    assign sp_dec     = i_sp - SPW'(1);
    assign sum        = i_rdata + i_tos;
    assign lt         = $signed(i_rdata) < $signed(i_tos);

    always_comb begin
        o_sp        = i_sp;
        o_tos       = i_tos;
        o_halt      = i_halt;
        o_mem_we    = 1'b0;
        o_mem_waddr = spm1_u[AW-1:0];
        o_mem_wdata = i_tos;
        delta       = PC_BITS'(1);
        fault       = smx_pkg::FLT_NONE;
        pv_valid    = 1'b0;
        pv          = '0;
        if (!i_halt) begin
            case (i_instr.kind)
                smx_pkg::OP_EXIT: begin
                    o_halt = 1'b1;
                    delta  = '0;
                end
                smx_pkg::OP_ADD, smx_pkg::OP_LESS: begin
                    if (sp_u < 32'd2) begin
                        fault = smx_pkg::FLT_UNDER;
                    end else begin
                        o_tos = (i_instr.kind == smx_pkg::OP_ADD) ? sum : 16'(lt);
                        o_sp  = sp_dec;
                    end
                end
                smx_pkg::OP_PUSH: begin
                    if (sp_full) begin
                        fault = smx_pkg::FLT_OVER;
                    end else begin
                        // spill the old top below the new one
                        o_mem_we = (sp_u != 32'd0);
                        o_tos    = i_instr.operand[15:0];
                        o_sp     = sp_inc;
                    end
                end
                smx_pkg::OP_PRINT: begin
                    if (sp_u == 32'd0) begin
                        fault = smx_pkg::FLT_UNDER;
                    end else begin
                        pv_valid = 1'b1;
                        pv       = i_tos;
                        o_tos    = i_rdata;
                        o_sp     = sp_dec;
                    end
                end
                smx_pkg::OP_LOAD: begin
                    if (sp_full) begin
                        fault = smx_pkg::FLT_OVER;
                    end else if (slot_bad) begin
                        fault = smx_pkg::FLT_SLOT;
                    end else begin
                        o_mem_we = 1'b1;
                        o_tos    = hit_top ? i_tos : i_rdata;
                        o_sp     = sp_inc;
                    end
                end
                smx_pkg::OP_STORE: begin
                    if (sp_u == 32'd0) begin
                        fault = smx_pkg::FLT_UNDER;
                    end else if (slot_bad) begin
                        fault = smx_pkg::FLT_SLOT;
                    end else begin
                        // a write at the top slot lands above the live region
                        o_mem_we    = 1'b1;
                        o_mem_waddr = op_u[AW-1:0];
                        o_tos       = hit_second ? i_tos : i_rdata;
                        o_sp        = sp_dec;
                    end
                end
                smx_pkg::OP_JZ: begin
                    if (sp_u == 32'd0) begin
                        fault = smx_pkg::FLT_UNDER;
                    end else begin
                        o_tos = i_rdata;
                        o_sp  = sp_dec;
                        if (i_tos == 16'd0) begin
                            delta = delta_u[PC_BITS-1:0];
                        end
                    end
                end
                smx_pkg::OP_JUMP: begin
                    delta = delta_u[PC_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_pc  = i_halt ? i_pc : (i_pc + delta);
    assign pc_u  = 32'(o_pc);
    assign lvl_u = 32'(o_sp);

    always_comb begin
        o_result             = '0;
        o_result.next_pc     = pc_u[15:0];
        o_result.print_valid = pv_valid;
        o_result.print_value = pv;
        o_result.halted      = o_halt;
        o_result.fault       = fault;
        o_result.stack_level = lvl_u[8:0];
    end

endmodule

[verif/stack_machine_executor_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// stack_machine_executor_unit_tb
// Self-checking bench for the stack machine executor. A program of directed
// and random instructions is built up front together with the result each
// one must give. The driver offers the instructions with random gaps, and
// the monitor takes results with random stalls, one long stall among them.
// Every result is compared field by field against the predicted one.
// ============================================================================
module stack_machine_executor_unit_tb;

    localparam int RAND_INSTRS    = 1950;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 300;
    localparam int STALL_AFTER    = 500;
    localparam int MAX_REPORTS    = 10;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               in_valid = 1'b0;
    smx_pkg::t_in_beat  in_beat  = '0;
    logic               out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    smx_pkg::t_out_beat o_out_beat;

    stack_machine_executor_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // machine state as the program sees it
    logic [15:0]                 mach_stack [smx_pkg::STACK_DEPTH];
    int                          mach_sp     = 0;
    logic [smx_pkg::PC_BITS-1:0] mach_pc     = '0;
    logic                        mach_halted = 1'b0;

    // program not yet driven, its predicted results, and results still owed
    smx_pkg::t_in_beat  prog_instrs  [$];
    smx_pkg::t_out_beat prog_results [$];
    smx_pkg::t_out_beat due_results  [$];

    int mismatches = 0;

    // execute one instruction on the machine state, give its result beat
    task automatic step_machine(input smx_pkg::t_in_beat ins,
                                output smx_pkg::t_out_beat res);
        smx_pkg::t_fault flt;
        int              slot;
        int              pc_step;
        logic [15:0]     lhs;
        logic [15:0]     rhs;
        flt     = smx_pkg::FLT_NONE;
        slot    = $signed(ins.operand);
        pc_step = 1;
        res     = '0;
        if (!mach_halted) begin
            case (ins.kind)
                smx_pkg::OP_EXIT: begin
                    mach_halted = 1'b1;
                    pc_step     = 0;
                end
                smx_pkg::OP_ADD, smx_pkg::OP_LESS: begin
                    if (mach_sp < 2) begin
                        flt = smx_pkg::FLT_UNDER;
                    end else begin
                        rhs = mach_stack[mach_sp - 1];
                        lhs = mach_stack[mach_sp - 2];
                        if (ins.kind == smx_pkg::OP_ADD) begin
                            mach_stack[mach_sp - 2] = lhs + rhs;
                        end else begin
                            mach_stack[mach_sp - 2] = {15'd0, $signed(lhs) < $signed(rhs)};
                        end
                        mach_sp--;
                    end
                end
                smx_pkg::OP_PUSH: begin
                    if (mach_sp >= smx_pkg::STACK_DEPTH) begin
                        flt = smx_pkg::FLT_OVER;
                    end else begin
                        mach_stack[mach_sp] = ins.operand;
                        mach_sp++;
                    end
                end
                smx_pkg::OP_PRINT: begin
                    if (mach_sp < 1) begin
                        flt = smx_pkg::FLT_UNDER;
                    end else begin
                        res.print_valid = 1'b1;
                        res.print_value = mach_stack[mach_sp - 1];
                        mach_sp--;
                    end
                end
                smx_pkg::OP_LOAD: begin
                    // overflow wins over a bad slot
                    if (mach_sp >= smx_pkg::STACK_DEPTH) begin
                        flt = smx_pkg::FLT_OVER;
                    end else if (slot < 0 || slot >= mach_sp) begin
                        flt = smx_pkg::FLT_SLOT;
                    end else begin
                        mach_stack[mach_sp] = mach_stack[slot];
                        mach_sp++;
                    end
                end
                smx_pkg::OP_STORE: begin
                    // underflow wins over a bad slot
                    if (mach_sp < 1) begin
                        flt = smx_pkg::FLT_UNDER;
                    end else if (slot < 0 || slot >= mach_sp) begin
                        flt = smx_pkg::FLT_SLOT;
                    end else begin
                        mach_stack[slot] = mach_stack[mach_sp - 1];
                        mach_sp--;
                    end
                end
                smx_pkg::OP_JZ: begin
                    if (mach_sp < 1) begin
                        flt = smx_pkg::FLT_UNDER;
                    end else begin
                        if (mach_stack[mach_sp - 1] == 16'd0) begin
                            pc_step = slot;
                        end
                        mach_sp--;
                    end
                end
                smx_pkg::OP_JUMP: begin
                    pc_step = slot;
                end
                default: begin
                    // undefined opcodes only move the pc on
                end
            endcase
            mach_pc = mach_pc + pc_step[smx_pkg::PC_BITS-1:0];
        end
        res.next_pc     = mach_pc;
        res.halted      = mach_halted;
        res.fault       = flt;
        res.stack_level = mach_sp[8:0];
    endtask

    task automatic queue_instr(input logic [3:0] kind, input logic [15:0] operand);
        smx_pkg::t_in_beat  ins;
        smx_pkg::t_out_beat res;
        ins.kind    = kind;
        ins.operand = operand;
        step_machine(ins, res);
        prog_instrs  = {prog_instrs, ins};
        prog_results = {prog_results, res};
    endtask

    // ------------------------------------------------------------------------
    // driver: one instruction per beat, random gap before each
    // ------------------------------------------------------------------------
    int send_gap   = 0;
    bit send_burst = 1'b0;

    always @(posedge i_clk) begin : drive_proc
        logic               nxt_valid;
        smx_pkg::t_in_beat  nxt_beat;
        smx_pkg::t_out_beat owed;
        nxt_valid = in_valid;
        nxt_beat  = in_beat;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            send_gap  = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                void'(prog_instrs.pop_front());
                owed        = prog_results.pop_front();
                due_results = {due_results, owed};
                nxt_valid   = 1'b0;
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
                send_gap = send_burst ? 0 : $urandom_range(0, 14);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (prog_instrs.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_beat  = prog_instrs[0];
                end
            end
        end
        in_valid <= nxt_valid;
        in_beat  <= nxt_beat;
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result beat, random stalls plus one long hold-off
    // ------------------------------------------------------------------------
    int results_seen = 0;
    int recv_wait    = 0;
    int stall_left   = 0;
    bit stall_done   = 1'b0;
    bit recv_burst   = 1'b0;

    always @(posedge i_clk) begin : monitor_proc
        smx_pkg::t_out_beat want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] result beat with nothing owed: pc %h fault %0d",
                                 $realtime, o_out_beat.next_pc, o_out_beat.fault);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (o_out_beat.next_pc     !== want.next_pc     ||
                        o_out_beat.print_valid !== want.print_valid ||
                        o_out_beat.print_value !== want.print_value ||
                        o_out_beat.halted      !== want.halted      ||
                        o_out_beat.fault       !== want.fault       ||
                        o_out_beat.stack_level !== want.stack_level) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] result %0d mismatch", $realtime, results_seen);
                            $display("  expected pc %h pv %b val %h halt %b fault %0d lvl %0d",
                                     want.next_pc, want.print_valid, want.print_value,
                                     want.halted, want.fault, want.stack_level);
                            $display("  actual   pc %h pv %b val %h halt %b fault %0d lvl %0d",
                                     o_out_beat.next_pc, o_out_beat.print_valid,
                                     o_out_beat.print_value, o_out_beat.halted,
                                     o_out_beat.fault, o_out_beat.stack_level);
                        end
                    end
                end
                results_seen++;
                // long hold-off so the block backs up onto its input
                if (!stall_done && results_seen == STALL_AFTER) begin
                    stall_left = LONG_STALL;
                    stall_done = 1'b1;
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_wait = recv_burst ? 0 : $urandom_range(0, 14);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog on cycles with no beat on either side
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $realtime, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // program, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int          mode;
        int          seg_left;
        int          n;
        int          r;
        int          r2;
        logic [3:0]  k;
        logic [15:0] v;

        // faults on an empty stack, underflow before bad slot on store
        queue_instr(smx_pkg::OP_PRINT, 16'h0000);
        queue_instr(smx_pkg::OP_ADD,   16'h0000);
        queue_instr(smx_pkg::OP_LESS,  16'hFFFF);
        queue_instr(smx_pkg::OP_JZ,    16'h0005);
        queue_instr(smx_pkg::OP_STORE, 16'h0000);
        queue_instr(smx_pkg::OP_LOAD,  16'h0000);
        // signed compare at the extremes, both outcomes
        queue_instr(smx_pkg::OP_PUSH,  16'h7FFF);
        queue_instr(smx_pkg::OP_PUSH,  16'h8000);
        queue_instr(smx_pkg::OP_LESS,  16'h0000);
        queue_instr(smx_pkg::OP_PUSH,  16'h8000);
        queue_instr(smx_pkg::OP_PUSH,  16'h7FFF);
        queue_instr(smx_pkg::OP_LESS,  16'h0000);
        // add wraps to zero
        queue_instr(smx_pkg::OP_PUSH,  16'hFFFF);
        queue_instr(smx_pkg::OP_PUSH,  16'h0001);
        queue_instr(smx_pkg::OP_ADD,   16'h0000);
        // bad slots: negative and at the stack pointer, then a valid load and store
        queue_instr(smx_pkg::OP_LOAD,  16'hFFFF);
        queue_instr(smx_pkg::OP_LOAD,  16'h0003);
        queue_instr(smx_pkg::OP_LOAD,  16'h0000);
        queue_instr(smx_pkg::OP_STORE, 16'h0004);
        queue_instr(smx_pkg::OP_STORE, 16'h8000);
        queue_instr(smx_pkg::OP_STORE, 16'h0001);
        // taken branches both ways, a far jump back and a jump of zero
        queue_instr(smx_pkg::OP_JZ,    16'h7FFF);
        queue_instr(smx_pkg::OP_JZ,    16'hFFFD);
        queue_instr(smx_pkg::OP_JUMP,  16'h8000);
        queue_instr(smx_pkg::OP_JUMP,  16'h0000);
        queue_instr(smx_pkg::OP_PRINT, 16'h0000);
        queue_instr(4'd15,             16'hFFFF);
        queue_instr(4'd9,              16'h0000);

        // random segments: filling, draining or mixed, with undefined noise
        n        = 0;
        seg_left = 0;
        mode     = 0;
        while (n < RAND_INSTRS) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 9);
                seg_left = $urandom_range(40, 400);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                k = 4'($urandom_range(9, 15));
            end else if (mode < 4) begin
                if (r < 70)      k = smx_pkg::OP_PUSH;
                else if (r < 88) k = smx_pkg::OP_LOAD;
                else             k = 4'($urandom_range(1, 8));
            end else if (mode < 7) begin
                if (r < 20)      k = smx_pkg::OP_ADD;
                else if (r < 35) k = smx_pkg::OP_LESS;
                else if (r < 50) k = smx_pkg::OP_PRINT;
                else if (r < 70) k = smx_pkg::OP_STORE;
                else if (r < 85) k = smx_pkg::OP_JZ;
                else             k = 4'($urandom_range(1, 8));
            end else begin
                k = 4'($urandom_range(1, 8));
            end
            r2 = $urandom_range(0, 9);
            case (k)
                smx_pkg::OP_LOAD, smx_pkg::OP_STORE: begin
                    if (r2 < 8 && mach_sp > 0) v = 16'($urandom_range(0, mach_sp - 1));
                    else if (r2 == 8)          v = 16'(mach_sp);
                    else                       v = 16'($urandom);
                end
                smx_pkg::OP_JZ, smx_pkg::OP_JUMP: begin
                    if (r2 < 5) v = 16'($urandom_range(0, 16)) - 16'd8;
                    else        v = 16'($urandom);
                end
                default: begin
                    case (r2)
                        0:       v = 16'h7FFF;
                        1:       v = 16'h8000;
                        2:       v = 16'h0000;
                        3:       v = 16'hFFFF;
                        default: v = 16'($urandom);
                    endcase
                end
            endcase
            queue_instr(k, v);
            n++;
        end

        // halt, then everything after it is ignored
        queue_instr(smx_pkg::OP_EXIT,  16'($urandom));
        queue_instr(smx_pkg::OP_PUSH,  16'h1234);
        queue_instr(smx_pkg::OP_JUMP,  16'h0010);
        queue_instr(smx_pkg::OP_PRINT, 16'h0000);
        queue_instr(smx_pkg::OP_EXIT,  16'h0000);
        queue_instr(4'd12,             16'hFFFF);

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (prog_instrs.size() != 0 || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        // let a stray late beat show up before the verdict
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
